/* sv/sic_pkg.sv */
// Shared types and constants of the streaming infix calculator.
package sic_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FIFO_DEPTH_DEF = 4;
	localparam int CH_W           = 8;
	localparam int VALUE_W        = 32;

	localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;

	typedef enum logic [1:0] {
		OP_PLUS   = 2'd0,
		OP_MINUS  = 2'd1,
		OP_TIMES  = 2'd2,
		OP_DIVIDE = 2'd3
	} op_t;

	localparam int OP_W = $bits(op_t);

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_BUSY,
		BK_FINISH
	} bk_state_t;

	typedef struct packed {
		logic start;
		logic is_div;
	} md_req_t;

endpackage

/* sv/sic_in_if.sv */
// Input channel: one expression character per beat.
interface sic_in_if;
	import sic_pkg::*;

	logic            valid;
	logic            ready;
	logic [CH_W-1:0] ch;
	logic            last;

	modport source (output valid, output ch, output last, input ready);
	modport sink   (input valid, input ch, input last, output ready);
endinterface

/* sv/sic_out_if.sv */
// Output channel: one expression result per beat.
interface sic_out_if;
	import sic_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic                      div_zero;

	modport source (output valid, output value, output div_zero, input ready);
	modport sink   (input valid, input value, input div_zero, output ready);
endinterface

/* sv/sic_front.sv */
// Front end: accepts characters, builds operands and pushes operator tokens.
module sic_front #(
	parameter int DATA_WIDTH = sic_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sic_in_if.sink                expr,
	input  logic                  q_full,
	output logic                  push,
	output logic [DATA_WIDTH-1:0] push_operand,
	output sic_pkg::op_t          push_op,
	output logic                  push_last
);
	import sic_pkg::*;

	logic [DATA_WIDTH-1:0] acc_q;
	op_t                   pend_op_q;
	logic                  accept;
	logic                  is_digit;
	logic                  closes;
	logic [DATA_WIDTH-1:0] acc_next;
	logic [CH_W-1:0]       digit_val;
	op_t                   ch_op;

	assign expr.ready = !q_full;
	assign accept     = expr.valid && expr.ready;
	assign is_digit   = (expr.ch >= CH_ZERO) && (expr.ch <= CH_NINE);
	assign closes     = (!is_digit && (expr.ch != CH_SPACE)) || expr.last;
	assign digit_val  = expr.ch - CH_ZERO;

	// times ten as two shifts and an add
	always_comb begin
		if (is_digit) begin
			acc_next = (acc_q << 3) + (acc_q << 1) + DATA_WIDTH'(digit_val[3:0]);
		end else begin
			acc_next = acc_q;
		end
	end

	// anything that is not + - * counts as divide
	always_comb begin
		if (expr.ch == CH_PLUS) begin
			ch_op = OP_PLUS;
		end else if (expr.ch == CH_MINUS) begin
			ch_op = OP_MINUS;
		end else if (expr.ch == CH_STAR) begin
			ch_op = OP_TIMES;
		end else begin
			ch_op = OP_DIVIDE;
		end
	end

	assign push         = accept && closes;
	assign push_operand = acc_next;
	assign push_op      = pend_op_q;
	assign push_last    = expr.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			pend_op_q <= OP_PLUS;
		end else if (accept) begin
			if (expr.last) begin
				acc_q     <= '0;
				pend_op_q <= OP_PLUS;
			end else if (closes) begin
				acc_q     <= '0;
				pend_op_q <= ch_op;
			end else begin
				acc_q <= acc_next;
			end
		end
	end

endmodule

/* sv/sic_fifo.sv */
// Token queue between front end and back end.
module sic_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = sic_pkg::FIFO_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* sv/sic_muldiv.sv */
// Shared iterative unit: shift-add multiply and restoring signed divide.
module sic_muldiv #(
	parameter int DATA_WIDTH = sic_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sic_pkg::md_req_t      req,
	input  logic [DATA_WIDTH-1:0] a,
	input  logic [DATA_WIDTH-1:0] b,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] result
);
	import sic_pkg::*;

	localparam int CNT_W = $clog2(DATA_WIDTH);

	logic                  busy_q;
	logic                  done_q;
	logic                  is_div_q;
	logic                  neg_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DATA_WIDTH-1:0] x_q;
	logic [DATA_WIDTH-1:0] y_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic [DATA_WIDTH-1:0] abs_a;
	logic [DATA_WIDTH-1:0] abs_b;
	logic [DATA_WIDTH-1:0] rem_sh;
	logic [DATA_WIDTH:0]   diff;

	assign abs_a  = a[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - a) : a;
	assign abs_b  = b[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - b) : b;
	assign rem_sh = {acc_q[DATA_WIDTH-2:0], x_q[DATA_WIDTH-1]};
	assign diff   = {1'b0, rem_sh} - {1'b0, y_q};

	assign done = done_q;
	always_comb begin
		if (!is_div_q) begin
			result = acc_q;
		end else if (neg_q) begin
			result = DATA_WIDTH'(0) - x_q;
		end else begin
			result = x_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DATA_WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			is_div_q <= req.is_div;
			neg_q    <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
			x_q      <= req.is_div ? abs_a : a;
			y_q      <= req.is_div ? abs_b : b;
			acc_q    <= '0;
		end else if (busy_q) begin
			if (is_div_q) begin
				// one quotient bit per cycle, shifted in at the bottom of x
				if (!diff[DATA_WIDTH]) begin
					acc_q <= diff[DATA_WIDTH-1:0];
					x_q   <= {x_q[DATA_WIDTH-2:0], 1'b1};
				end else begin
					acc_q <= rem_sh;
					x_q   <= {x_q[DATA_WIDTH-2:0], 1'b0};
				end
			end else begin
				if (y_q[0]) begin
					acc_q <= acc_q + x_q;
				end
				x_q <= {x_q[DATA_WIDTH-2:0], 1'b0};
				y_q <= {1'b0, y_q[DATA_WIDTH-1:1]};
			end
		end
	end

endmodule

/* sv/sic_back.sv */
// Back end: applies operator tokens to the running sum and term, emits results.
module sic_back #(
	parameter int DATA_WIDTH = sic_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  logic [DATA_WIDTH-1:0] q_operand,
	input  sic_pkg::op_t          q_op,
	input  logic                  q_last,
	output logic                  q_pop,
	output sic_pkg::md_req_t      md_req,
	output logic [DATA_WIDTH-1:0] md_a,
	output logic [DATA_WIDTH-1:0] md_b,
	input  logic                  md_done,
	input  logic [DATA_WIDTH-1:0] md_result,
	sic_out_if.source             result
);
	import sic_pkg::*;

	bk_state_t             state_q;
	bk_state_t             state_d;
	logic [DATA_WIDTH-1:0] sum_q;
	logic [DATA_WIDTH-1:0] sum_d;
	logic [DATA_WIDTH-1:0] term_q;
	logic [DATA_WIDTH-1:0] term_d;
	logic                  err_q;
	logic                  err_d;
	logic                  last_q;
	logic                  last_d;
	logic                  out_valid_q;
	logic                  out_valid_d;
	logic [DATA_WIDTH-1:0] out_raw_q;
	logic [DATA_WIDTH-1:0] out_raw_d;
	logic                  out_err_q;
	logic                  out_err_d;
	logic                  out_free;
	logic [DATA_WIDTH-1:0] total;

	assign total    = sum_q + term_q;
	assign out_free = !out_valid_q || result.ready;
	assign md_a     = term_q;
	assign md_b     = q_operand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		sum_d       = sum_q;
		term_d      = term_q;
		err_d       = err_q;
		last_d      = last_q;
		out_raw_d   = out_raw_q;
		out_err_d   = out_err_q;
		out_valid_d = out_valid_q && !result.ready;
		q_pop       = 1'b0;
		md_req      = '0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop  = 1'b1;
					last_d = q_last;
					case (q_op)
						OP_PLUS: begin
							sum_d   = total;
							term_d  = q_operand;
							state_d = q_last ? BK_FINISH : BK_IDLE;
						end
						OP_MINUS: begin
							sum_d   = total;
							term_d  = DATA_WIDTH'(0) - q_operand;
							state_d = q_last ? BK_FINISH : BK_IDLE;
						end
						OP_TIMES: begin
							md_req.start  = 1'b1;
							md_req.is_div = 1'b0;
							state_d       = BK_BUSY;
						end
						default: begin
							if (q_operand == '0) begin
								// divide by zero: flag it, term drops to zero
								err_d   = 1'b1;
								term_d  = '0;
								state_d = q_last ? BK_FINISH : BK_IDLE;
							end else begin
								md_req.start  = 1'b1;
								md_req.is_div = 1'b1;
								state_d       = BK_BUSY;
							end
						end
					endcase
				end
			end
			BK_BUSY: begin
				if (md_done) begin
					term_d  = md_result;
					state_d = last_q ? BK_FINISH : BK_IDLE;
				end
			end
			BK_FINISH: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					out_raw_d   = total;
					out_err_d   = err_q;
					sum_d       = '0;
					term_d      = '0;
					err_d       = 1'b0;
					state_d     = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			term_q      <= '0;
			err_q       <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			sum_q       <= sum_d;
			term_q      <= term_d;
			err_q       <= err_d;
			last_q      <= last_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		out_raw_q <= out_raw_d;
		out_err_q <= out_err_d;
	end

	assign result.valid    = out_valid_q;
	assign result.div_zero = out_err_q;

	// sign-extend a narrow datapath, keep the low bits of a wide one
	generate
		if (DATA_WIDTH >= VALUE_W) begin : g_trunc
			assign result.value = out_raw_q[VALUE_W-1:0];
		end else begin : g_sext
			assign result.value = {{(VALUE_W-DATA_WIDTH){out_raw_q[DATA_WIDTH-1]}}, out_raw_q};
		end
	endgenerate

endmodule

/* sv/streaming_infix_calculator.sv */
// Top level of the streaming infix calculator: front end, token queue, back end.
//
//   channel | dir | payload              | beat
//   --------+-----+----------------------+------------------------------------
//   expr    | in  | ch[7:0], last        | one ASCII character of the expression
//   result  | out | value[31:0], div_zero| one result per expression
//
// Digits and spaces are absorbed in the front end and push no token unless they carry last.
// Each operator (and the last character) becomes a token in the queue; the back
// end retires a + or - token (or a / by zero, flagged) directly and hands a * or /
// token to the shared iterative multiply/divide unit (one bit per cycle), waiting in BK_BUSY.
// The last token then passes through BK_FINISH, which loads the result register.
// Reset clears control state, queue pointers and sums at once; no clearing pass.
// The front end stalls expr only when the queue is full; the back end stalls
// on the multiply/divide unit and when a new result waits on a held previous one.
module streaming_infix_calculator #(
	parameter int DATA_WIDTH = sic_pkg::DATA_WIDTH_DEF,
	parameter int FIFO_DEPTH = sic_pkg::FIFO_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sic_in_if.sink    expr,
	sic_out_if.source result
);
	import sic_pkg::*;

	localparam int TOK_W = DATA_WIDTH + OP_W + 1;

	logic                  push;
	logic [DATA_WIDTH-1:0] push_operand;
	op_t                   push_op;
	logic                  push_last;
	logic                  q_full;
	logic                  q_empty;
	logic                  q_pop;
	logic [TOK_W-1:0]      q_data;
	logic [DATA_WIDTH-1:0] q_operand;
	op_t                   q_op;
	logic                  q_last;
	md_req_t               md_req;
	logic [DATA_WIDTH-1:0] md_a;
	logic [DATA_WIDTH-1:0] md_b;
	logic                  md_done;
	logic [DATA_WIDTH-1:0] md_result;

	// classify characters, build operands, push one token per operator and on the last character
	sic_front #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.expr         (expr),
		.q_full       (q_full),
		.push         (push),
		.push_operand (push_operand),
		.push_op      (push_op),
		.push_last    (push_last)
	);

	// token layout: last, pending operator, closed operand
	sic_fifo #(
		.WIDTH (TOK_W),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_last, push_op, push_operand}),
		.pop       (q_pop),
		.pop_data  (q_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	assign q_operand = q_data[DATA_WIDTH-1:0];
	assign q_op      = op_t'(q_data[DATA_WIDTH +: OP_W]);
	assign q_last    = q_data[TOK_W-1];

	// apply tokens to sum and term, hold the result for the sink
	sic_back #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_operand (q_operand),
		.q_op      (q_op),
		.q_last    (q_last),
		.q_pop     (q_pop),
		.md_req    (md_req),
		.md_a      (md_a),
		.md_b      (md_b),
		.md_done   (md_done),
		.md_result (md_result),
		.result    (result)
	);

	// one bit per cycle for both multiply and divide
	sic_muldiv #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.a      (md_a),
		.b      (md_b),
		.done   (md_done),
		.result (md_result)
	);

endmodule
